### rtl/core/lzrd_pkg.sv
package lzrd_pkg;

	localparam int RING_BYTES = 4096;
	localparam int RING_AW    = $clog2(RING_BYTES);
	localparam int LEN_W      = 24;
	localparam int CNT_W      = 5;
	localparam int FILL_W     = RING_AW + 1;

	localparam logic [RING_AW-1:0] START_POS = RING_AW'(12'hFEE);
	localparam logic [CNT_W-1:0]   MIN_MATCH = CNT_W'(3);

	// controller to datapath
	typedef struct packed {
		logic take;        // input transaction this cycle
		logic emit_copy;   // emit one byte of a back reference
	} lzrd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic copy_start;  // current input byte opens a back reference copy
		logic copy_last;   // byte in flight is the last of the copy
		logic out_free;    // output register can take a byte this cycle
	} lzrd_stat_t;

endpackage

### rtl/core/lzrd_ram.sv
module lzrd_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// one write port, one registered read port (old data on collision)
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/lzrd_ctrl.sv
module lzrd_ctrl
	import lzrd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  lzrd_stat_t stat,
	output lzrd_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_COPY
	} state_t;

	state_t state_q;

	// take input only when a literal could go straight to the output
	assign s_tready      = (state_q == ST_IDLE) && stat.out_free;
	assign cmd.take      = s_tvalid && s_tready;
	assign cmd.emit_copy = (state_q == ST_COPY) && stat.out_free;

	// sequence a back reference: prime the ring read, then stream bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take && stat.copy_start) begin
						state_q <= ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (cmd.emit_copy && stat.copy_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	ap_prime_to_copy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRIME |=> state_q == ST_COPY)
		else $error("prime cycle not followed by copy");

	ap_copy_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_copy && stat.copy_last |=> state_q == ST_IDLE && !cmd.emit_copy)
		else $error("copy did not end after its last byte");

endmodule

### rtl/core/lzrd_dp.sv
module lzrd_dp
	import lzrd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,
	input  logic [7:0]       s_tdata,
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser,
	input  lzrd_cmd_t        cmd,
	output lzrd_stat_t       stat
);

	typedef enum logic [1:0] {
		PH_FLAGS = 2'd0,
		PH_ITEM  = 2'd1,
		PH_HIGH  = 2'd2
	} phase_t;

	logic [LEN_W-1:0]   out_len_q;
	logic [RING_AW-1:0] wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [LEN_W-1:0]   rem_q;
	logic [8:0]         flags_q;
	logic [7:0]         low_q;
	phase_t             phase_q;
	logic [RING_AW-1:0] rd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               out_done_q;

	logic               valid_s1;
	logic               byp_s1;
	logic [7:0]         byp_data_s1;

	logic               st;
	logic [RING_AW-1:0] eff_wp;
	logic [FILL_W-1:0]  eff_fill;
	logic [LEN_W-1:0]   eff_rem;
	logic [8:0]         eff_flags;
	phase_t             eff_phase;
	logic               live;
	logic               lit_emit;
	logic               we;
	logic [RING_AW-1:0] waddr;
	logic [7:0]         wdata;
	logic [7:0]         ram_rdata;
	logic [RING_AW-1:0] raddr;
	logic [RING_AW-1:0] roff;
	logic [7:0]         copy_byte;
	logic [8:0]         nxt_flags;
	logic [CNT_W-1:0]   req_len;
	logic [CNT_W-1:0]   clip_len;
	logic [RING_AW-1:0] src;

	// stream start applies before the byte is decoded
	assign st        = cmd.take && s_tuser;
	assign eff_wp    = st ? START_POS : wp_q;
	assign eff_fill  = st ? '0 : fill_q;
	assign eff_rem   = st ? out_len_q : rem_q;
	assign eff_flags = st ? '0 : flags_q;
	assign eff_phase = st ? PH_FLAGS : phase_q;
	assign live      = (eff_rem != '0);

	assign lit_emit  = cmd.take && live && (eff_phase == PH_ITEM) && eff_flags[0];
	assign nxt_flags = eff_flags >> 1;

	// back reference fields, clipped to what is left of the stream
	assign req_len  = CNT_W'(s_tdata[3:0]) + MIN_MATCH;
	assign clip_len = (eff_rem < LEN_W'(req_len)) ? eff_rem[CNT_W-1:0] : req_len;
	assign src      = {s_tdata[7:4], low_q};

	assign stat.copy_start = !s_tuser && (rem_q != '0) && (phase_q == PH_HIGH);
	assign stat.copy_last  = (cnt_q == CNT_W'(1));
	assign stat.out_free   = !out_valid_q || m_tready;

	// ring write: literal from input or byte of a copy
	assign we    = lit_emit || cmd.emit_copy;
	assign waddr = lit_emit ? eff_wp : wp_q;
	assign wdata = lit_emit ? s_tdata : copy_byte;

	// advance the read address together with each emitted byte
	assign raddr = cmd.emit_copy ? rd_q + RING_AW'(1) : rd_q;
	assign roff  = raddr - START_POS;

	// unwritten entries read as zero; same-cycle write is forwarded
	assign copy_byte = byp_s1 ? byp_data_s1 : (valid_s1 ? ram_rdata : 8'h00);

	lzrd_ram #(
		.DATA_W (8),
		.DEPTH  (RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// track ring read validity and forwarding
	always_ff @(posedge clk) begin
		valid_s1    <= ({1'b0, roff} < fill_q);
		byp_s1      <= cmd.emit_copy && (raddr == wp_q);
		byp_data_s1 <= copy_byte;
	end

	// hold configuration and stream position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_len_q <= '0;
			wp_q      <= START_POS;
			fill_q    <= '0;
			rem_q     <= '0;
			flags_q   <= '0;
			low_q     <= '0;
			phase_q   <= PH_FLAGS;
			rd_q      <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				out_len_q <= cfg_wdata;
			end
			wp_q   <= eff_wp + RING_AW'(we);
			fill_q <= eff_fill + FILL_W'(we && !eff_fill[FILL_W-1]);
			rem_q  <= eff_rem - LEN_W'(we);
			if (cmd.take) begin
				flags_q <= eff_flags;
				phase_q <= eff_phase;
				if (st) begin
					low_q <= '0;
				end
				if (live) begin
					unique case (eff_phase)
						PH_ITEM: begin
							if (eff_flags[0]) begin
								flags_q <= nxt_flags;
								phase_q <= (nxt_flags <= 9'd1) ? PH_FLAGS : PH_ITEM;
							end else begin
								low_q   <= s_tdata;
								phase_q <= PH_HIGH;
							end
						end
						PH_HIGH: begin
							rd_q    <= src;
							cnt_q   <= clip_len;
							flags_q <= nxt_flags;
							phase_q <= (nxt_flags <= 9'd1) ? PH_FLAGS : PH_ITEM;
						end
						default: begin
							flags_q <= {1'b1, s_tdata};
							phase_q <= PH_ITEM;
						end
					endcase
				end
			end else if (cmd.emit_copy) begin
				rd_q  <= raddr;
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (we) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			out_byte_q <= wdata;
			out_last_q <= lit_emit || stat.copy_last;
			out_done_q <= (eff_rem == LEN_W'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

	ap_copy_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_copy |-> rem_q != '0 && cnt_q != '0)
		else $error("copy byte emitted with nothing left");

	ap_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> m_tvalid && (m_tuser == (rem_q == '0)))
		else $error("stream done flag disagrees with remaining count");

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(RING_BYTES))
		else $error("ring fill count past ring size");

endmodule

### rtl/core/lzss_ring_decoder.sv
// LZSS decoder with a 4096-byte history ring.
// Input channel s_*: one compressed byte per transaction; s_tuser set on the
// first byte of a stream reloads the ring position (0xFEE), the flag state
// and the remaining count from output_length, and empties the ring.
// Output channel m_*: one decoded byte per transaction; m_tlast marks the
// last byte produced by one input byte, m_tuser the byte that completes the
// configured output length. Bytes after that are taken and dropped.
// cfg_we/cfg_wdata write output_length; it is used at the next stream start.
// A literal is on m_tdata in the cycle after its transaction. A back
// reference of n bytes (3..18, clipped to the remaining count) shows its
// first byte after its second input byte has passed the prime state, the copy
// state and the output register, then one byte per cycle while the receiver
// takes them; input is held off during the prime and copy states. The single
// read port of the ring sets the copy rate of one byte per cycle.
// When the receiver stalls, the output register holds its byte, a copy
// pauses in place and s_tready stays low. Reset empties the ring at once
// (a fill count masks unwritten entries) and needs no clearing pass.
module lzss_ring_decoder
	import lzrd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_wdata,   // output_length
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,     // [7:0] in_byte
	input  logic             s_tuser,     // [0] start_of_stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,     // [7:0] out_byte
	output logic             m_tlast,
	output logic             m_tuser      // [0] stream_done
);

	lzrd_cmd_t  cmd;
	lzrd_stat_t stat;

	lzrd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzrd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### tb/sv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lzrd_pkg::*;

	// decoder position within the compressed stream
	typedef enum logic [1:0] {PH_FLAGS, PH_ITEM, PH_HIGH} phase_e;

	// one decoded byte as it leaves the output channel
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} dec_byte_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

	// directed stimulus: a length write, or one compressed byte with an
	// optional hand-written expectation (n_out copies of out_val)
	typedef struct packed {
		row_kind_e   kind;
		logic [23:0] value;
		logic        sos;
		logic        typed;
		logic [4:0]  n_out;
		logic [7:0]  out_val;
		logic        done_last;
	} row_t;

	localparam int N_DIR = 25;
	localparam row_t DIR_ROWS [N_DIR] = '{
		// never started: ignored
		'{ROW_BYTE, 24'h0000FF, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		// zero output length: ignored
		'{ROW_CFG,  24'h000000, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000AA, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000000, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		// 20 bytes: literal, reference, literal, reference clipped at the end
		'{ROW_CFG,  24'h000014, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000005, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000FF, 1'b0, 1'b1, 5'd1,  8'hFF, 1'b0},
		'{ROW_BYTE, 24'h000000, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000000, 1'b0, 1'b1, 5'd3,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000000, 1'b0, 1'b1, 5'd1,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000EE, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000FF, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		// stream complete: trailing byte dropped
		'{ROW_BYTE, 24'h000012, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		// largest length, all references, source wraps past the ring end
		'{ROW_CFG,  24'hFFFFFF, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000000, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000FF, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000F0, 1'b0, 1'b1, 5'd3,  8'h00, 1'b0},
		// length written mid-stream: used at the next start only
		'{ROW_CFG,  24'h000007, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000034, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h00002A, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h00005C, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		// restart in the middle of a reference
		'{ROW_BYTE, 24'h000081, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h000080, 1'b0, 1'b1, 5'd1,  8'h80, 1'b0},
		'{ROW_BYTE, 24'h0000FE, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
		'{ROW_BYTE, 24'h0000EA, 1'b0, 1'b0, 5'd0,  8'h00, 1'b0}
	};

	localparam int RANDOM_ITEMS = 220;
	localparam int LONG_HOLD    = 300;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [LEN_W-1:0] cfg_wdata;
	logic             s_tvalid;
	logic             s_tready;
	logic [7:0]       s_tdata;     // [7:0] in_byte
	logic             s_tuser;     // [0] start_of_stream
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;     // [7:0] out_byte
	logic             m_tlast;
	logic             m_tuser;     // [0] stream_done

	// decoder shadow state
	logic [7:0]       hist [RING_BYTES];
	logic [11:0]      wr_pos;
	logic [8:0]       flag_bits;
	logic [7:0]       ref_low;
	phase_e           phase;
	logic [23:0]      remaining;
	logic [23:0]      out_len;

	dec_byte_t        step_bytes [$];
	dec_byte_t        pending_bytes [$];
	int               errors = 0;
	bit               burst = 1'b0;
	bit               long_hold_req = 1'b0;

	lzss_ring_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// idle length: mostly short, now and then long
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// store one decoded byte in the ring and queue it
	task automatic put_byte(input logic [7:0] v, input logic last);
		hist[wr_pos] = v;
		wr_pos = wr_pos + 12'd1;
		remaining = remaining - 24'd1;
		step_bytes.push_back('{v, last, remaining == 24'd0});
	endtask

	task automatic advance_flags();
		flag_bits = flag_bits >> 1;
		phase = (flag_bits <= 9'd1) ? PH_FLAGS : PH_ITEM;
	endtask

	// decode one compressed byte into step_bytes
	task automatic decode_byte(input logic [7:0] b, input logic sos);
		logic [11:0] src;
		int unsigned len;
		step_bytes.delete();
		if (sos) begin
			foreach (hist[i])
				hist[i] = 8'h00;
			wr_pos = START_POS;
			flag_bits = '0;
			ref_low = '0;
			phase = PH_FLAGS;
			remaining = out_len;
		end
		if (remaining == 24'd0)
			return;
		case (phase)
			PH_ITEM: begin
				if (flag_bits[0]) begin
					put_byte(b, 1'b1);
					advance_flags();
				end else begin
					ref_low = b;
					phase = PH_HIGH;
				end
			end
			PH_HIGH: begin
				len = b[3:0] + MIN_MATCH;
				src = {b[7:4], ref_low};
				if (len > remaining)
					len = remaining;
				// copy reads see bytes written earlier in the same copy
				for (int unsigned i = 0; i < len; i++)
					put_byte(hist[src + 12'(i)], i == len - 1);
				advance_flags();
			end
			default: begin
				flag_bits = {1'b1, b};
				phase = PH_ITEM;
			end
		endcase
	endtask

	// offer one byte, wait for its transaction, queue what it yields
	task automatic send_byte(input row_t r);
		int g;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= r.value[7:0];
		s_tuser  <= r.sos;
		do
			@(posedge clk);
		while (!s_tready);
		decode_byte(r.value[7:0], r.sos);
		if (r.typed) begin
			for (int k = 0; k < int'(r.n_out); k++)
				pending_bytes.push_back('{r.out_val, k == int'(r.n_out) - 1,
					r.done_last && k == int'(r.n_out) - 1});
		end else begin
			foreach (step_bytes[k])
				pending_bytes.push_back(step_bytes[k]);
		end
		g = 0;
		if (!burst && $urandom_range(0, 99) < 35)
			g = pick_gap();
		if (g > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	// drop valid and let every expected byte drain, then settle
	task automatic drain(input int settle);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_length(input logic [23:0] v);
		drain(25);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		out_len = v;
	endtask

	// receiver: random stalls, a long hold on request, none in burst mode
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!burst && $urandom_range(0, 99) < 12) begin
				hold_left = pick_gap() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// compare each output transaction with the oldest expectation
	always @(posedge clk) begin
		dec_byte_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected output byte %02h", m_tdata);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data) begin
					$error("out_byte: expected %02h, got %02h", want.data, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
					errors++;
				end
				if (m_tuser !== want.done) begin
					$error("stream_done: expected %0b, got %0b", want.done, m_tuser);
					errors++;
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	initial begin
		logic [23:0] olen;
		logic [7:0]  b;
		logic [3:0]  ref_hi;
		logic [11:0] src;
		logic        sos;
		int          fed;
		int          stream_no;
		int          budget;
		int          sent;

		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		foreach (hist[i])
			hist[i] = 8'h00;
		wr_pos    = START_POS;
		flag_bits = '0;
		ref_low   = '0;
		phase     = PH_FLAGS;
		remaining = '0;
		out_len   = '0;
		ref_hi    = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			if (DIR_ROWS[i].kind == ROW_CFG)
				write_length(DIR_ROWS[i].value);
			else
				send_byte(DIR_ROWS[i]);
		end

		// random streams: well-formed content, some restarts and trailing junk
		fed = 0;
		stream_no = 0;
		while (fed < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:        olen = 24'd0;
				1:        olen = 24'hFFFFFF;
				2, 3, 4:  olen = 24'($urandom_range(41, 200));
				default:  olen = 24'($urandom_range(1, 40));
			endcase
			if (stream_no == 2)
				olen = 24'd120;
			if (stream_no < 3 || $urandom_range(0, 3) != 0)
				write_length(olen);
			olen = out_len;
			burst = (stream_no % 5 == 3);
			// hold the receiver off while the sender keeps offering bytes
			if (stream_no == 2) begin
				burst = 1'b0;
				long_hold_req = 1'b1;
			end
			if (olen == 24'd0)
				budget = $urandom_range(1, 2);
			else if (olen == 24'hFFFFFF)
				budget = 40;
			else
				budget = 150;

			send_byte('{ROW_BYTE, 24'($urandom_range(0, 255)), 1'b1, 1'b0, 5'd0,
				8'h00, 1'b0});
			sent = 1;
			if (olen != 24'd0)
				fed++;
			while (remaining != 24'd0 && sent < budget) begin
				sos = 1'b0;
				case (phase)
					PH_ITEM: begin
						if (flag_bits[0]) begin
							b = 8'($urandom_range(0, 255));
						end else begin
							// mostly reach back into recent output
							if ($urandom_range(0, 99) < 80)
								src = wr_pos - 12'($urandom_range(1, 64));
							else
								src = 12'($urandom_range(0, 4095));
							ref_hi = src[11:8];
							b = src[7:0];
						end
					end
					PH_HIGH: b = {ref_hi, 4'($urandom_range(0, 15))};
					default: b = 8'($urandom_range(0, 255));
				endcase
				// noise: restart anywhere, or a stray byte
				if ($urandom_range(0, 59) == 0)
					sos = 1'b1;
				else if ($urandom_range(0, 59) == 0)
					b = 8'($urandom_range(0, 255));
				send_byte('{ROW_BYTE, 24'(b), sos, 1'b0, 5'd0, 8'h00, 1'b0});
				sent++;
				fed++;
			end
			// trailing bytes after completion are dropped
			repeat ($urandom_range(0, 2))
				send_byte('{ROW_BYTE, 24'($urandom_range(0, 255)), 1'b0, 1'b0, 5'd0,
					8'h00, 1'b0});
			stream_no++;
		end
		burst = 1'b0;

		drain(40);
		if (pending_bytes.size() != 0) begin
			$error("%0d expected bytes never arrived", pending_bytes.size());
			errors++;
		end
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/core/lzrd_pkg.sv
rtl/core/lzrd_ram.sv
rtl/core/lzrd_ctrl.sv
rtl/core/lzrd_dp.sv
rtl/core/lzss_ring_decoder.sv
tb/sv/testbench.sv
